@@ sv/ycsk_pkg.sv @@
// ----------------------------------------------------------------------------
// ycsk_pkg
// Shared constants for the YCbCr ellipse skin classifier: fixed-point color
// conversion weights, register indexes, register reset values and the chroma helper.
// ----------------------------------------------------------------------------
package ycsk_pkg;

   // color conversion weights, scaled by 2^14
   localparam logic [13:0]        LUMA_KR    = 14'd4899;
   localparam logic [13:0]        LUMA_KG    = 14'd9617;
   localparam logic [13:0]        LUMA_KB    = 14'd1868;
   localparam logic signed [14:0] CR_K       = 15'sd11682;
   localparam logic signed [14:0] CB_K       = 15'sd9241;
   localparam int                 FIX_SHIFT  = 14;
   localparam logic [21:0]        LUMA_HALF  = 22'd8192;
   localparam logic signed [23:0] CHR_HALF   = 24'sd8192;
   localparam logic signed [10:0] CHROMA_MID = 11'sd128;
   localparam logic [7:0]         SKIN_ON    = 8'd255;
   localparam logic [7:0]         SKIN_OFF   = 8'd0;

   // register indexes on the csr port
   localparam logic [2:0] CSR_LUMA_THRESHOLD = 3'd0;
   localparam logic [2:0] CSR_CENTRE_CB      = 3'd1;
   localparam logic [2:0] CSR_CENTRE_CR      = 3'd2;
   localparam logic [2:0] CSR_COEF_DX_SQ     = 3'd3;
   localparam logic [2:0] CSR_COEF_CROSS     = 3'd4;
   localparam logic [2:0] CSR_COEF_DY_SQ     = 3'd5;
   localparam logic [2:0] CSR_ELLIPSE_LIMIT  = 3'd6;

   // register reset values
   localparam logic [7:0]         RST_LUMA_THRESHOLD = 8'd128;
   localparam logic [7:0]         RST_CENTRE_CB      = 8'd113;
   localparam logic [7:0]         RST_CENTRE_CR      = 8'd156;
   localparam logic [15:0]        RST_COEF_DX_SQ     = 16'd5862;
   localparam logic signed [16:0] RST_COEF_CROSS     = -17'sd4852;
   localparam logic [15:0]        RST_COEF_DY_SQ     = 16'd6202;
   localparam logic [31:0]        RST_ELLIPSE_LIMIT  = 32'd1904400;

   // 128 + floor((diff*k + 2^13) / 2^14), saturated to 0..255
   function automatic logic [7:0] chroma_of(input logic signed [8:0]  diff,
                                            input logic signed [14:0] k);
      logic signed [23:0] t;
      logic signed [9:0]  sh;
      logic signed [10:0] c;
      t  = diff * k + CHR_HALF;
      sh = t[23:FIX_SHIFT];
      c  = $signed({sh[9], sh}) + CHROMA_MID;
      if (c < 11'sd0) begin
         chroma_of = 8'd0;
      end else if (c > 11'sd255) begin
         chroma_of = 8'd255;
      end else begin
         chroma_of = c[7:0];
      end
   endfunction

endpackage

@@ sv/ycbcr_ellipse_skin_classifier.sv @@
// ----------------------------------------------------------------------------
// ycbcr_ellipse_skin_classifier
// Classifies BGR pixels as skin by a luma threshold and a rotated ellipse
// test in the CbCr plane.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one mask byte per pixel, 255 for
// skin and 0 otherwise, in order. The datapath is a five-stage pipeline:
// luma, chroma with saturation, chroma offsets and their products, the
// coefficient multiplies, and the quadratic-form sum with both compares.
// Throughput is one pixel per cycle while responses are taken. Each
// stage holds while the stage after it is full and stalled, so empty
// stages still fill while a response waits to be taken. Registers are to
// be written through the csr port while no pixel is in flight; the
// block does not enforce this. Indexes past the last register are ignored.
module ycbcr_ellipse_skin_classifier
   import ycsk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // pixel requests
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_red,
   // mask responses
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_skin_mask,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   // configuration registers
   logic [7:0]         luma_threshold_ff;
   logic [7:0]         centre_cb_ff;
   logic [7:0]         centre_cr_ff;
   logic [15:0]        coef_dx_sq_ff;
   logic signed [16:0] coef_cross_ff;
   logic [15:0]        coef_dy_sq_ff;
   logic [31:0]        ellipse_limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         luma_threshold_ff <= RST_LUMA_THRESHOLD;
         centre_cb_ff      <= RST_CENTRE_CB;
         centre_cr_ff      <= RST_CENTRE_CR;
         coef_dx_sq_ff     <= RST_COEF_DX_SQ;
         coef_cross_ff     <= RST_COEF_CROSS;
         coef_dy_sq_ff     <= RST_COEF_DY_SQ;
         ellipse_limit_ff  <= RST_ELLIPSE_LIMIT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LUMA_THRESHOLD: luma_threshold_ff <= csr_data[7:0];
            CSR_CENTRE_CB:      centre_cb_ff      <= csr_data[7:0];
            CSR_CENTRE_CR:      centre_cr_ff      <= csr_data[7:0];
            CSR_COEF_DX_SQ:     coef_dx_sq_ff     <= csr_data[15:0];
            CSR_COEF_CROSS:     coef_cross_ff     <= $signed(csr_data[16:0]);
            CSR_COEF_DY_SQ:     coef_dy_sq_ff     <= csr_data[15:0];
            CSR_ELLIPSE_LIMIT:  ellipse_limit_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline registers
   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic               rsp_valid_ff;
   logic [7:0]         s1_y_ff, s2_y_ff, s3_y_ff, s4_y_ff;
   logic [7:0]         s1_blue_ff, s1_red_ff;
   logic [7:0]         s2_cb_ff, s2_cr_ff;
   logic [15:0]        s3_dxx_ff, s3_dyy_ff;
   logic signed [16:0] s3_dxy_ff;
   logic [31:0]        s4_txx_ff, s4_tyy_ff;
   logic signed [33:0] s4_txy_ff;
   logic [7:0]         rsp_skin_mask_ff;

   // stage advance: a stage loads when it is empty or its contents move on
   logic adv1, adv2, adv3, adv4, adv5;
   assign adv5 = !rsp_valid_ff || rsp_ready;
   assign adv4 = !s4_valid_ff || adv5;
   assign adv3 = !s3_valid_ff || adv4;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;

   assign req_ready     = adv1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_skin_mask = rsp_skin_mask_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff  <= req_valid;
         if (adv2) s2_valid_ff  <= s1_valid_ff;
         if (adv3) s3_valid_ff  <= s2_valid_ff;
         if (adv4) s4_valid_ff  <= s3_valid_ff;
         if (adv5) rsp_valid_ff <= s4_valid_ff;
      end
   end

   // stage 1: luma
   logic [21:0] ysum_in;
   assign ysum_in = LUMA_KR * {14'd0, req_red} + LUMA_KG * {14'd0, req_green}
                  + LUMA_KB * {14'd0, req_blue} + LUMA_HALF;

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_y_ff    <= ysum_in[21:FIX_SHIFT];
         s1_blue_ff <= req_blue;
         s1_red_ff  <= req_red;
      end
   end

   // stage 2: chroma differences, scaling and saturation
   logic signed [8:0] rdiff_in, bdiff_in;
   assign rdiff_in = $signed({1'b0, s1_red_ff})  - $signed({1'b0, s1_y_ff});
   assign bdiff_in = $signed({1'b0, s1_blue_ff}) - $signed({1'b0, s1_y_ff});

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_y_ff  <= s1_y_ff;
         s2_cr_ff <= chroma_of(rdiff_in, CR_K);
         s2_cb_ff <= chroma_of(bdiff_in, CB_K);
      end
   end

   // stage 3: offsets from the ellipse centre and their products
   logic signed [8:0]  dx_in, dy_in;
   logic signed [17:0] dxx_in, dxy_in, dyy_in;
   assign dx_in  = $signed({1'b0, s2_cb_ff}) - $signed({1'b0, centre_cb_ff});
   assign dy_in  = $signed({1'b0, s2_cr_ff}) - $signed({1'b0, centre_cr_ff});
   assign dxx_in = 18'(dx_in) * 18'(dx_in);
   assign dxy_in = 18'(dx_in) * 18'(dy_in);
   assign dyy_in = 18'(dy_in) * 18'(dy_in);

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_y_ff   <= s2_y_ff;
         s3_dxx_ff <= dxx_in[15:0];
         s3_dxy_ff <= dxy_in[16:0];
         s3_dyy_ff <= dyy_in[15:0];
      end
   end

   // stage 4: weight each product by its coefficient
   logic [31:0]        txx_in, tyy_in;
   logic signed [33:0] txy_in;
   assign txx_in = 32'(coef_dx_sq_ff) * 32'(s3_dxx_ff);
   assign tyy_in = 32'(coef_dy_sq_ff) * 32'(s3_dyy_ff);
   assign txy_in = 34'(coef_cross_ff) * 34'(s3_dxy_ff);

   always_ff @(posedge clock) begin
      if (adv4) begin
         s4_y_ff   <= s3_y_ff;
         s4_txx_ff <= txx_in;
         s4_txy_ff <= txy_in;
         s4_tyy_ff <= tyy_in;
      end
   end

   // stage 5: sum of the quadratic form, ellipse and luma compares
   logic signed [35:0] q_in;
   logic               skin_in;
   assign q_in = $signed({4'd0, s4_txx_ff}) + $signed({{2{s4_txy_ff[33]}}, s4_txy_ff})
               + $signed({4'd0, s4_tyy_ff});
   assign skin_in = (s4_y_ff > luma_threshold_ff)
                 && (q_in <= $signed({4'd0, ellipse_limit_ff}));

   always_ff @(posedge clock) begin
      if (adv5) begin
         rsp_skin_mask_ff <= skin_in ? SKIN_ON : SKIN_OFF;
      end
   end

endmodule

@@ verif/ycbcr_ellipse_skin_classifier_test.sv @@
// ----------------------------------------------------------------------------
// ycbcr_ellipse_skin_classifier_test
// Self-checking bench for the elliptical CbCr skin classifier. Pixels go in
// over the request channel with bursty timing, masks come back under a
// stalling receiver, and every mask is checked against a local prediction of
// the luma gate and the quadratic-form ellipse test. Register settings are
// swept between phases, including the extremes and random values.
// ----------------------------------------------------------------------------
module ycbcr_ellipse_skin_classifier_test
   import ycsk_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // index past the last register, writes to it are dropped
   localparam logic [2:0] CSR_UNUSED = 3'd7;
   localparam int         NUM_REGS   = 7;
   localparam int         PIPE_DEPTH = 5;
   localparam int         NUM_PHASES = 8;
   localparam int         PHASE_PIXELS = 66;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       known;
      logic [7:0] mask;
   } pixel_row_type;

   // directed pixels; masks typed in only where obvious
   localparam int NUM_ROWS = 20;
   localparam pixel_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{8'd0,   8'd0,   8'd0,   1'b1, SKIN_OFF},  // black
      '{8'd255, 8'd255, 8'd255, 1'b1, SKIN_OFF},  // white, far off the ellipse
      '{8'd0,   8'd0,   8'd255, 1'b1, SKIN_OFF},  // red, dark luma, Cr saturates
      '{8'd255, 8'd0,   8'd0,   1'b1, SKIN_OFF},  // blue, dark luma, Cb at the top of its range
      '{8'd128, 8'd128, 8'd128, 1'b1, SKIN_OFF},  // luma equals threshold
      '{8'd0,   8'd255, 8'd0,   1'b0, SKIN_OFF},  // green
      '{8'd255, 8'd255, 8'd0,   1'b0, SKIN_OFF},  // cyan, Cr at the bottom of its range
      '{8'd255, 8'd0,   8'd255, 1'b0, SKIN_OFF},  // magenta
      '{8'd0,   8'd255, 8'd255, 1'b0, SKIN_OFF},  // yellow, Cb near the bottom of its range
      '{8'd120, 8'd150, 8'd200, 1'b0, SKIN_OFF},  // skin tones
      '{8'd100, 8'd140, 8'd210, 1'b0, SKIN_OFF},
      '{8'd90,  8'd120, 8'd180, 1'b0, SKIN_OFF},
      '{8'd140, 8'd170, 8'd230, 1'b0, SKIN_OFF},
      '{8'd80,  8'd110, 8'd170, 1'b0, SKIN_OFF},
      '{8'd130, 8'd160, 8'd220, 1'b0, SKIN_OFF},
      '{8'hAA,  8'h55,  8'hAA,  1'b0, SKIN_OFF},  // alternating bits
      '{8'h55,  8'hAA,  8'h55,  1'b0, SKIN_OFF},
      '{8'd1,   8'd1,   8'd1,   1'b0, SKIN_OFF},
      '{8'd254, 8'd254, 8'd254, 1'b0, SKIN_OFF},
      '{8'd129, 8'd129, 8'd129, 1'b0, SKIN_OFF}   // luma just above threshold
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_blue = 8'd0;
   logic [7:0]  req_green = 8'd0;
   logic [7:0]  req_red = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_skin_mask;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = 3'd0;
   logic [31:0] csr_data = 32'd0;

   // local copy of the register file
   logic [7:0]         cfg_thr     = RST_LUMA_THRESHOLD;
   logic [7:0]         cfg_cb      = RST_CENTRE_CB;
   logic [7:0]         cfg_cr      = RST_CENTRE_CR;
   logic [15:0]        cfg_dx_sq   = RST_COEF_DX_SQ;
   logic signed [16:0] cfg_cross   = RST_COEF_CROSS;
   logic [15:0]        cfg_dy_sq   = RST_COEF_DY_SQ;
   logic [31:0]        cfg_limit   = RST_ELLIPSE_LIMIT;

   logic [7:0] mask_expect [$];
   int         error_count = 0;
   int         masks_seen = 0;
   int         burst_left = 0;

   ycbcr_ellipse_skin_classifier DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_blue      (req_blue),
      .req_green     (req_green),
      .req_red       (req_red),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_skin_mask (rsp_skin_mask),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #5 clock = ~clock;

   // 128 + floor((diff*k + half) / 2^14), saturated
   function automatic int chroma_sat(input int diff, input int k);
      int t;
      int c;
      t = diff * k + int'(CHR_HALF);
      c = int'(CHROMA_MID) + (t >>> FIX_SHIFT);
      if (c < 0) c = 0;
      if (c > 255) c = 255;
      return c;
   endfunction

   // luma and quadratic form of one pixel under the current registers
   function automatic void pixel_point(input logic [7:0] b, input logic [7:0] g,
                                       input logic [7:0] r, output int y,
                                       output longint q);
      int     cb;
      int     cr;
      longint dx;
      longint dy;
      y  = (int'(LUMA_KR) * int'(r) + int'(LUMA_KG) * int'(g) +
            int'(LUMA_KB) * int'(b) + int'(LUMA_HALF)) >> FIX_SHIFT;
      cr = chroma_sat(int'(r) - y, int'(CR_K));
      cb = chroma_sat(int'(b) - y, int'(CB_K));
      dx = longint'(cb) - longint'(cfg_cb);
      dy = longint'(cr) - longint'(cfg_cr);
      q  = longint'(cfg_dx_sq) * dx * dx + longint'(cfg_cross) * dx * dy +
           longint'(cfg_dy_sq) * dy * dy;
   endfunction

   function automatic logic [7:0] skin_of(input logic [7:0] b, input logic [7:0] g,
                                          input logic [7:0] r);
      int     y;
      longint q;
      pixel_point(b, g, r, y, q);
      if (y > int'(cfg_thr) && q <= longint'(cfg_limit)) return SKIN_ON;
      return SKIN_OFF;
   endfunction

   // register write as the block keeps it: low bits only
   function automatic void csr_apply(input logic [2:0] idx, input logic [31:0] data);
      case (idx)
         CSR_LUMA_THRESHOLD: cfg_thr   = data[7:0];
         CSR_CENTRE_CB:      cfg_cb    = data[7:0];
         CSR_CENTRE_CR:      cfg_cr    = data[7:0];
         CSR_COEF_DX_SQ:     cfg_dx_sq = data[15:0];
         CSR_COEF_CROSS:     cfg_cross = data[16:0];
         CSR_COEF_DY_SQ:     cfg_dy_sq = data[15:0];
         CSR_ELLIPSE_LIMIT:  cfg_limit = data;
         default: ;
      endcase
   endfunction

   // value with random junk above the register width
   function automatic logic [31:0] junk_hi(input logic [31:0] value, input int width);
      logic [31:0] keep;
      keep = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
      return (value & keep) | ($urandom() & ~keep);
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_apply(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // one pixel request, then the burst/gap pattern of the sender
   task automatic send_pixel(input logic [7:0] b, input logic [7:0] g,
                             input logic [7:0] r, input logic known,
                             input logic [7:0] mask);
      int gap;
      req_valid <= 1'b1;
      req_blue  <= b;
      req_green <= g;
      req_red   <= r;
      do @(posedge clock); while (!req_ready);
      mask_expect.push_back(known ? mask : skin_of(b, g, r));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            req_blue  <= 8'($urandom());
            req_green <= 8'($urandom());
            req_red   <= 8'($urandom());
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // stop offering and wait until every mask is back
   task automatic drain();
      req_valid <= 1'b0;
      while (mask_expect.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH) @(posedge clock);
   endtask

   // mostly skin-like tones, some saturated corners, some noise
   task automatic gen_pixel(output logic [7:0] b, output logic [7:0] g,
                            output logic [7:0] r);
      int sel;
      int ri;
      int gi;
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
         ri = $urandom_range(80, 255);
         gi = ri * $urandom_range(45, 95) / 100;
         r  = ri[7:0];
         g  = gi[7:0];
         b  = 8'(gi * $urandom_range(55, 105) / 100);
      end else if (sel == 6) begin
         b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
         b = 8'($urandom());
         g = 8'($urandom());
         r = 8'($urandom());
      end
   endtask

   // mask checker and receiver stall pattern
   int hold_left = 0;
   bit hold_done = 1'b0;
   int rx_mode = 0;
   int rx_mode_left = 0;
   int rx_tick = 0;

   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         masks_seen++;
         if (mask_expect.size() == 0) begin
            $error("unexpected mask response: actual %0d", rsp_skin_mask);
            error_count++;
         end else begin
            want = mask_expect.pop_front();
            if (rsp_skin_mask !== want) begin
               $error("skin_mask mismatch: expected %0d, actual %0d", want, rsp_skin_mask);
               error_count++;
            end
         end
      end
      rx_tick++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && masks_seen == 300) begin
         // long hold-off so the pipeline fills and backs up the requests
         hold_done = 1'b1;
         hold_left = 120;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(10, 60);
         end
         rx_mode_left--;
         case (rx_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= ($urandom_range(0, 7) != 0);
            default: rsp_ready <= ((rx_tick % 5) < 2);
         endcase
      end
   end

   // run limit
   initial begin
      #3_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // stimulus
   initial begin
      logic [31:0] vals [NUM_REGS];
      logic [7:0]  b;
      logic [7:0]  g;
      logic [7:0]  r;
      int          y;
      longint      q;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pixels under reset settings
      for (int i = 0; i < NUM_ROWS; i++) begin
         send_pixel(DIRECTED_ROWS[i].blue, DIRECTED_ROWS[i].green, DIRECTED_ROWS[i].red,
                    DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].mask);
      end
      drain();

      // point exactly on the ellipse boundary, then just outside
      pixel_point(8'd120, 8'd150, 8'd200, y, q);
      if (q >= 0 && q <= 64'hFFFF_FFFF) begin
         csr_write(CSR_ELLIPSE_LIMIT, q[31:0]);
         send_pixel(8'd120, 8'd150, 8'd200, 1'b0, SKIN_OFF);
         drain();
         if (q > 0) begin
            csr_write(CSR_ELLIPSE_LIMIT, 32'(q - 1));
            send_pixel(8'd120, 8'd150, 8'd200, 1'b0, SKIN_OFF);
            drain();
         end
      end

      // luma exactly at the threshold, then one below; wide data on the way
      csr_write(CSR_ELLIPSE_LIMIT, 32'hFFFF_FFFF);
      csr_write(CSR_LUMA_THRESHOLD, junk_hi(32'(y), 8));
      send_pixel(8'd120, 8'd150, 8'd200, 1'b0, SKIN_OFF);
      drain();
      csr_write(CSR_LUMA_THRESHOLD, junk_hi(32'(y - 1), 8));
      // write past the register list must change nothing
      csr_write(CSR_UNUSED, $urandom());
      send_pixel(8'd120, 8'd150, 8'd200, 1'b0, SKIN_OFF);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0, SKIN_OFF);
      drain();

      // random phases over several register settings
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin
               vals[CSR_LUMA_THRESHOLD] = junk_hi(32'(RST_LUMA_THRESHOLD), 8);
               vals[CSR_CENTRE_CB]      = junk_hi(32'(RST_CENTRE_CB), 8);
               vals[CSR_CENTRE_CR]      = junk_hi(32'(RST_CENTRE_CR), 8);
               vals[CSR_COEF_DX_SQ]     = junk_hi(32'(RST_COEF_DX_SQ), 16);
               vals[CSR_COEF_CROSS]     = junk_hi(32'(unsigned'(RST_COEF_CROSS)), 17);
               vals[CSR_COEF_DY_SQ]     = junk_hi(32'(RST_COEF_DY_SQ), 16);
               vals[CSR_ELLIPSE_LIMIT]  = RST_ELLIPSE_LIMIT;
            end
            1: begin
               // all weights zero: every pixel above zero luma is skin
               vals[CSR_LUMA_THRESHOLD] = 32'd0;
               vals[CSR_CENTRE_CB]      = 32'd0;
               vals[CSR_CENTRE_CR]      = 32'd255;
               vals[CSR_COEF_DX_SQ]     = 32'd0;
               vals[CSR_COEF_CROSS]     = 32'd0;
               vals[CSR_COEF_DY_SQ]     = 32'd0;
               vals[CSR_ELLIPSE_LIMIT]  = 32'd0;
            end
            2: begin
               vals[CSR_LUMA_THRESHOLD] = 32'd255;
               vals[CSR_CENTRE_CB]      = 32'd255;
               vals[CSR_CENTRE_CR]      = 32'd0;
               vals[CSR_COEF_DX_SQ]     = 32'd65535;
               vals[CSR_COEF_CROSS]     = 32'h0000_FFFF;
               vals[CSR_COEF_DY_SQ]     = 32'd65535;
               vals[CSR_ELLIPSE_LIMIT]  = 32'hFFFF_FFFF;
            end
            3: begin
               // most negative cross weight
               vals[CSR_LUMA_THRESHOLD] = 32'd0;
               vals[CSR_CENTRE_CB]      = 32'd128;
               vals[CSR_CENTRE_CR]      = 32'd128;
               vals[CSR_COEF_DX_SQ]     = 32'd65535;
               vals[CSR_COEF_CROSS]     = 32'h0001_0000;
               vals[CSR_COEF_DY_SQ]     = 32'd65535;
               vals[CSR_ELLIPSE_LIMIT]  = 32'hFFFF_FFFF;
            end
            default: begin
               vals[CSR_LUMA_THRESHOLD] = junk_hi($urandom_range(0, 160), 8);
               vals[CSR_CENTRE_CB]      = junk_hi($urandom_range(90, 140), 8);
               vals[CSR_CENTRE_CR]      = junk_hi($urandom_range(130, 180), 8);
               vals[CSR_COEF_DX_SQ]     = $urandom();
               vals[CSR_COEF_CROSS]     = $urandom();
               vals[CSR_COEF_DY_SQ]     = $urandom() >> $urandom_range(0, 6);
               vals[CSR_ELLIPSE_LIMIT]  = $urandom() >> $urandom_range(0, 8);
            end
         endcase
         for (int i = 0; i < NUM_REGS; i++) begin
            csr_write(3'(i), vals[i]);
         end

         for (int n = 0; n < PHASE_PIXELS; n++) begin
            // one pause mid-stream until every mask is back
            if (p == 4 && n == PHASE_PIXELS / 2) drain();
            gen_pixel(b, g, r);
            send_pixel(b, g, r, 1'b0, SKIN_OFF);
         end
         drain();
      end

      repeat (4 * PIPE_DEPTH) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
